// ===== src/caal_pkg.sv =====
// shared types, codes and constants for the alias allocation link
package caal_pkg;

    localparam int unsigned NODE_ID_W  = 48;
    localparam int unsigned GEN_W      = 24;
    localparam int unsigned ALIAS_W    = 12;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CONFIRM_W  = 16;
    localparam int unsigned STEP_CNT_W = 4;

    localparam logic [GEN_W-1:0]      GEN_ADD_LOW   = 24'h7A4BA9;
    localparam logic [GEN_W-1:0]      GEN_ADD_HIGH  = 24'h1B0CA3;
    localparam logic [CONFIRM_W-1:0]  CONFIRM_RESET = 16'd200;
    localparam logic [STEP_CNT_W-1:0] ADV_LIMIT     = 4'd8;

    // configuration register indexes
    localparam logic CFG_NODE_ID = 1'b0;
    localparam logic CFG_CONFIRM = 1'b1;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_RX      = 2'd1,
        KIND_SEED    = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        FR_NONE     = 3'd0,
        FR_CHECK    = 3'd1,
        FR_RESERVE  = 3'd2,
        FR_DEFINE   = 3'd3,
        FR_MAPRESET = 3'd4,
        FR_INITDONE = 3'd5,
        FR_VERIFIED = 3'd6
    } frame_t;

    typedef enum logic [3:0] {
        PH_CHECK0    = 4'd0,
        PH_CHECK1    = 4'd1,
        PH_CHECK2    = 4'd2,
        PH_CHECK3    = 4'd3,
        PH_WAIT_ARM  = 4'd4,
        PH_WAIT      = 4'd5,
        PH_ASSIGNED  = 4'd6,
        PH_PERMITTED = 4'd7,
        PH_INIT      = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_STEP,
        ST_CHK,
        ST_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic step;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic adv_step;
        logic adv_check;
        logic alias_zero;
    } status_t;

endpackage

// ===== src/caal_ctrl.sv =====
// sequencer for item capture, evaluation, generator stepping and result hand-off
module caal_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  caal_pkg::status_t st,
    output caal_pkg::cmd_t    cmd
);

    caal_pkg::ctrl_state_t                state_reg, state_next;
    logic [caal_pkg::STEP_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                                 out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= caal_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            caal_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = caal_pkg::ST_EVAL;
                end
            end
            caal_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                cnt_next = '0;
                priority if (st.adv_step)
                    state_next = caal_pkg::ST_STEP;
                else if (st.adv_check)
                    state_next = caal_pkg::ST_CHK;
                else
                    state_next = caal_pkg::ST_PUSH;
            end
            caal_pkg::ST_STEP:
            begin
                cmd.step   = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = caal_pkg::ST_CHK;
            end
            caal_pkg::ST_CHK:
            begin
                // keep stepping while the alias is zero, bounded by the limit
                if (st.alias_zero && (cnt_reg != caal_pkg::ADV_LIMIT))
                    state_next = caal_pkg::ST_STEP;
                else
                    state_next = caal_pkg::ST_PUSH;
            end
            caal_pkg::ST_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.push       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = caal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = caal_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != caal_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= caal_pkg::ADV_LIMIT)
        else $error("generator step count above limit");

    a_step_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == caal_pkg::ST_STEP |-> cnt_reg < caal_pkg::ADV_LIMIT)
        else $error("generator step issued at limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || !out_stall))
        else $error("result pushed over a waiting item");

    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == caal_pkg::ST_EVAL)
        else $error("accepted item not evaluated next cycle");

endmodule

// ===== src/caal_dp.sv =====
// datapath: config, generator, phase state, item decode and result registers
module caal_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  caal_pkg::cmd_t                      cmd,
    output caal_pkg::status_t                   st,
    input  logic                                cfg_wr,
    input  logic                                cfg_index,
    input  logic [caal_pkg::NODE_ID_W-1:0]      cfg_data,
    input  logic [1:0]                          kind,
    input  logic [caal_pkg::TIME_W-1:0]         now_ms,
    input  logic                                tx_ready,
    input  logic [caal_pkg::ALIAS_W-1:0]        source_alias,
    input  logic                                is_check_id,
    input  logic                                is_map_enquiry,
    input  logic                                has_payload,
    input  logic                                node_id_matches,
    input  logic                                is_verify_request,
    output logic [2:0]                          frame_kind,
    output logic [1:0]                          check_index,
    output logic [caal_pkg::ALIAS_W-1:0]        id_fragment,
    output logic [caal_pkg::ALIAS_W-1:0]        alias_res,
    output logic                                handled,
    output logic                                initialized
);

    localparam int unsigned GW = caal_pkg::GEN_W;
    localparam int unsigned AW = caal_pkg::ALIAS_W;

    // configuration
    logic [caal_pkg::NODE_ID_W-1:0] node_id_reg;
    logic [caal_pkg::CONFIRM_W-1:0] confirm_reg;

    // block state
    logic [GW-1:0]                  gen_high_reg, gen_high_next;
    logic [GW-1:0]                  gen_low_reg, gen_low_next;
    caal_pkg::phase_t               phase_reg, phase_next;
    logic [caal_pkg::TIME_W-1:0]    wait_start_reg, wait_start_next;

    // captured item
    caal_pkg::kind_t                kind_reg;
    logic [caal_pkg::TIME_W-1:0]    now_reg;
    logic                           ready_reg;
    logic [AW-1:0]                  src_reg;
    logic                           cim_reg;
    logic                           ame_reg;
    logic                           payload_reg;
    logic                           match_reg;
    logic                           verify_reg;

    // pending result and output stage
    caal_pkg::frame_t               res_fk_reg, res_fk_next;
    logic [1:0]                     res_cidx_reg, res_cidx_next;
    logic [AW-1:0]                  res_frag_reg, res_frag_next;
    logic [AW-1:0]                  res_alias_reg, res_alias_next;
    logic                           res_handled_reg, res_handled_next;
    logic                           res_init_reg, res_init_next;

    caal_pkg::frame_t               out_fk_reg;
    logic [1:0]                     out_cidx_reg;
    logic [AW-1:0]                  out_frag_reg;
    logic [AW-1:0]                  out_alias_reg;
    logic                           out_handled_reg;
    logic                           out_init_reg;

    logic [AW-1:0]                  cur_alias;
    logic [GW+1:0]                  lo_sum;
    logic [GW-1:0]                  hi_sum;
    logic [GW-1:0]                  step_low;
    logic [GW-1:0]                  step_high;
    logic [caal_pkg::TIME_W-1:0]    elapsed;
    logic                           collide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= '0;
            confirm_reg <= caal_pkg::CONFIRM_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == caal_pkg::CFG_NODE_ID)
                node_id_reg <= cfg_data;
            else
                confirm_reg <= cfg_data[caal_pkg::CONFIRM_W-1:0];
        end
    end

    assign cur_alias = gen_high_reg[AW-1:0] ^ gen_low_reg[AW-1:0]
                     ^ gen_high_reg[GW-1:AW] ^ gen_low_reg[GW-1:AW];

    // one step of x * 513 + constant over the 48-bit pair
    assign lo_sum    = {2'b00, gen_low_reg} + {2'b00, gen_low_reg[GW-10:0], 9'b0}
                     + {2'b00, caal_pkg::GEN_ADD_LOW};
    assign hi_sum    = gen_high_reg + {gen_high_reg[GW-10:0], gen_low_reg[GW-1:GW-9]}
                     + caal_pkg::GEN_ADD_HIGH;
    assign step_low  = lo_sum[GW-1:0];
    assign step_high = hi_sum + {{(GW-2){1'b0}}, lo_sum[GW+1:GW]};

    assign elapsed = now_reg - wait_start_reg;
    assign collide = (src_reg == cur_alias);

    assign st.adv_step   = (kind_reg == caal_pkg::KIND_RESTART)
                        || ((kind_reg == caal_pkg::KIND_RX) && collide && !cim_reg);
    assign st.adv_check  = (kind_reg == caal_pkg::KIND_SEED);
    assign st.alias_zero = (cur_alias == '0);

    always_comb
    begin
        res_fk_next      = caal_pkg::FR_NONE;
        res_cidx_next    = '0;
        res_frag_next    = '0;
        res_handled_next = 1'b0;
        phase_next       = phase_reg;
        wait_start_next  = wait_start_reg;
        gen_high_next    = gen_high_reg;
        gen_low_next     = gen_low_reg;

        unique case (kind_reg)
            caal_pkg::KIND_TICK:
            begin
                unique case (phase_reg)
                    caal_pkg::PH_CHECK0, caal_pkg::PH_CHECK1,
                    caal_pkg::PH_CHECK2, caal_pkg::PH_CHECK3:
                    begin
                        if (ready_reg)
                        begin
                            res_fk_next   = caal_pkg::FR_CHECK;
                            res_cidx_next = phase_reg[1:0];
                            unique case (phase_reg[1:0])
                                2'd0: res_frag_next = node_id_reg[47:36];
                                2'd1: res_frag_next = node_id_reg[35:24];
                                2'd2: res_frag_next = node_id_reg[23:12];
                                default: res_frag_next = node_id_reg[11:0];
                            endcase
                            phase_next = caal_pkg::phase_t'(4'(phase_reg) + 4'd1);
                        end
                    end
                    caal_pkg::PH_WAIT_ARM:
                    begin
                        wait_start_next = now_reg;
                        phase_next      = caal_pkg::PH_WAIT;
                    end
                    caal_pkg::PH_WAIT:
                    begin
                        if ((elapsed > {16'b0, confirm_reg}) && ready_reg)
                        begin
                            res_fk_next = caal_pkg::FR_RESERVE;
                            phase_next  = caal_pkg::PH_ASSIGNED;
                        end
                    end
                    caal_pkg::PH_ASSIGNED:
                    begin
                        if (ready_reg)
                        begin
                            res_fk_next = caal_pkg::FR_DEFINE;
                            phase_next  = caal_pkg::PH_PERMITTED;
                        end
                    end
                    caal_pkg::PH_PERMITTED:
                    begin
                        if (ready_reg)
                        begin
                            res_fk_next = caal_pkg::FR_INITDONE;
                            phase_next  = caal_pkg::PH_INIT;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            caal_pkg::KIND_RX:
            begin
                priority if (collide)
                begin
                    if (cim_reg)
                        res_fk_next = caal_pkg::FR_RESERVE;
                    else
                    begin
                        if (ready_reg)
                            res_fk_next = caal_pkg::FR_MAPRESET;
                        phase_next = caal_pkg::PH_CHECK0;
                    end
                end
                else if (ame_reg)
                begin
                    if (!payload_reg || match_reg)
                        res_fk_next = caal_pkg::FR_DEFINE;
                end
                else if (verify_reg)
                begin
                    res_fk_next      = caal_pkg::FR_VERIFIED;
                    res_handled_next = 1'b1;
                end
                else
                begin
                    res_fk_next = caal_pkg::FR_NONE;
                end
            end
            caal_pkg::KIND_SEED:
            begin
                gen_high_next = node_id_reg[47:24];
                gen_low_next  = node_id_reg[23:0];
            end
            default:
            begin
                phase_next = caal_pkg::PH_CHECK0;
            end
        endcase

        res_alias_next = (res_fk_next == caal_pkg::FR_NONE) ? '0 : cur_alias;
        res_init_next  = (phase_next == caal_pkg::PH_INIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_high_reg   <= '0;
            gen_low_reg    <= '0;
            phase_reg      <= caal_pkg::PH_CHECK0;
            wait_start_reg <= '0;
        end
        else if (cmd.eval)
        begin
            gen_high_reg   <= gen_high_next;
            gen_low_reg    <= gen_low_next;
            phase_reg      <= phase_next;
            wait_start_reg <= wait_start_next;
        end
        else if (cmd.step)
        begin
            gen_high_reg <= step_high;
            gen_low_reg  <= step_low;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= caal_pkg::kind_t'(kind);
            now_reg     <= now_ms;
            ready_reg   <= tx_ready;
            src_reg     <= source_alias;
            cim_reg     <= is_check_id;
            ame_reg     <= is_map_enquiry;
            payload_reg <= has_payload;
            match_reg   <= node_id_matches;
            verify_reg  <= is_verify_request;
        end
        if (cmd.eval)
        begin
            res_fk_reg      <= res_fk_next;
            res_cidx_reg    <= res_cidx_next;
            res_frag_reg    <= res_frag_next;
            res_alias_reg   <= res_alias_next;
            res_handled_reg <= res_handled_next;
            res_init_reg    <= res_init_next;
        end
        if (cmd.push)
        begin
            out_fk_reg      <= res_fk_reg;
            out_cidx_reg    <= res_cidx_reg;
            out_frag_reg    <= res_frag_reg;
            out_alias_reg   <= res_alias_reg;
            out_handled_reg <= res_handled_reg;
            out_init_reg    <= res_init_reg;
        end
    end

    assign frame_kind  = out_fk_reg;
    assign check_index = out_cidx_reg;
    assign id_fragment = out_frag_reg;
    assign alias_res   = out_alias_reg;
    assign handled     = out_handled_reg;
    assign initialized = out_init_reg;

endmodule

// ===== src/can_alias_allocation_link_unit.sv =====
// top level of the CAN alias allocation link: sequencer plus datapath
//
// Claims a 12-bit CAN alias for the configured 48-bit node id and tells the
// transmitter which frame to send for each event item (tick, received frame,
// seed, restart); every accepted item yields exactly one result item, with
// frame_kind none when nothing is to be sent. Items are handled one at a time:
// a result is offered once its item has passed the evaluate and push states,
// and the next item can be accepted once the sequencer is back in idle; a
// seed also passes a check state for the new alias, and each generator step
// adds a step and a check state when the alias has to be advanced (at most 8
// steps); the step loop runs on a single 48-bit multiply-by-513 adder in the
// datapath. The result sits in an output register, so the next item is
// accepted while a result waits to be taken.
// Config writes are always ready and must be made while the block is idle.
module can_alias_allocation_link_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [caal_pkg::NODE_ID_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          kind,
    input  logic [caal_pkg::TIME_W-1:0]         now_ms,
    input  logic                                tx_ready,
    input  logic [caal_pkg::ALIAS_W-1:0]        source_alias,
    input  logic                                is_check_id,
    input  logic                                is_map_enquiry,
    input  logic                                has_payload,
    input  logic                                node_id_matches,
    input  logic                                is_verify_request,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          frame_kind,
    output logic [1:0]                          check_index,
    output logic [caal_pkg::ALIAS_W-1:0]        id_fragment,
    output logic [caal_pkg::ALIAS_W-1:0]        alias_res,
    output logic                                handled,
    output logic                                initialized
);

    caal_pkg::cmd_t    cmd;
    caal_pkg::status_t st;
    logic              cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    caal_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    caal_dp u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .st                (st),
        .cfg_wr            (cfg_wr),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .kind              (kind),
        .now_ms            (now_ms),
        .tx_ready          (tx_ready),
        .source_alias      (source_alias),
        .is_check_id       (is_check_id),
        .is_map_enquiry    (is_map_enquiry),
        .has_payload       (has_payload),
        .node_id_matches   (node_id_matches),
        .is_verify_request (is_verify_request),
        .frame_kind        (frame_kind),
        .check_index       (check_index),
        .id_fragment       (id_fragment),
        .alias_res         (alias_res),
        .handled           (handled),
        .initialized       (initialized)
    );

endmodule
